/* sv/qsud_pkg.sv */
// Shared types and helpers for the quoted string unescape decoder.
// Used by qsud_decode and quoted_string_unescape_decoder; no dependencies.
`default_nettype none

package qsud_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_BAD_OPEN = 2'd2;
    localparam logic [1:0] KIND_BAD_ESC  = 2'd3;

    localparam logic [7:0] CH_BSL    = 8'h5C;  // backslash
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_UP_U   = 8'h55;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // result queue depth, two slots per transfer plus slack
    localparam int unsigned QDEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RAW  = 2'd1,
        MODE_ESC  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_BSL  = 2'd1,
        PH_HEX  = 2'd2,
        PH_OCT  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_first;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       run_end;
    } t_out_item;

    typedef struct packed {
        t_mode      mode;
        t_phase     phase;
        logic [1:0] digit_count;    // octal digits taken so far
        logic [3:0] digits_needed;  // hex digits still to come
        logic [7:0] acc;            // partial octal value or high hex nibble
        logic       err;
    } t_state;

    // 5-bit value, 16 means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c inside {[8'h30:8'h39]}) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            v = 5'd9 + {2'b00, c[2:0]};
        end
        return v;
    endfunction

    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] b;
        case (c)
            8'h62:   b = 8'h08;  // b
            8'h66:   b = 8'h0C;  // f
            8'h6E:   b = 8'h0A;  // n
            8'h72:   b = 8'h0D;  // r
            8'h74:   b = 8'h09;  // t
            8'h61:   b = 8'h07;  // a
            8'h76:   b = 8'h0B;  // v
            default: b = c;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* sv/qsud_decode.sv */
// Next-state and result logic for one character of a quoted literal.
// Purely combinational; depends on qsud_pkg.
`default_nettype none

module qsud_decode
    import qsud_pkg::*;
(
    input  wire t_state    i_state,
    input  wire t_in_item  i_item,
    output t_state         o_state,
    output t_out_item      o_res0,
    output t_out_item      o_res1,
    output logic [1:0]     o_count
);

    t_state     s;
    t_out_item  res [2];
    logic [1:0] cnt;
    logic [7:0] c;
    logic       last;
    logic       plain;
    logic [4:0] hv;
    logic       is_oct;

    always_comb begin
        s      = i_state;
        res[0] = '0;
        res[1] = '0;
        cnt    = 2'd0;
        c      = i_item.ch;
        last   = i_item.is_last;
        plain  = 1'b0;
        hv     = hex_value(c);
        is_oct = c inside {[8'h30:8'h37]};

        if (i_item.is_first) begin
            s = '0;
            if (c == CH_SQUOTE) begin
                s.mode = MODE_RAW;
            end else if (c == CH_DQUOTE) begin
                s.mode = MODE_ESC;
            end else begin
                res[cnt[0]].kind = KIND_BAD_OPEN;
                cnt = cnt + 2'd1;
            end
            if (s.mode != MODE_IDLE && last) begin
                res[cnt[0]].kind = KIND_DONE;
                cnt = cnt + 2'd1;
                s = '0;
            end
        end else if (s.mode == MODE_IDLE) begin
            // stray character outside a string
        end else if (s.err) begin
            if (last) begin
                s = '0;
            end
        end else if (s.mode == MODE_RAW) begin
            if (last) begin
                res[cnt[0]].kind = KIND_DONE;
                cnt = cnt + 2'd1;
                s = '0;
            end else begin
                res[cnt[0]].out_byte = c;
                cnt = cnt + 2'd1;
            end
        end else begin
            if (s.phase == PH_OCT) begin
                if (!last && is_oct && s.digit_count != 2'd3) begin
                    s.acc = {s.acc[4:0], c[2:0]};
                    if (s.digit_count == 2'd2) begin
                        res[cnt[0]].out_byte = s.acc;
                        cnt = cnt + 2'd1;
                        s.phase = PH_NONE;
                        s.digit_count = 2'd0;
                        s.acc = '0;
                    end else begin
                        s.digit_count = s.digit_count + 2'd1;
                    end
                end else begin
                    // non-octal or last char ends escape; then handled normally
                    res[cnt[0]].out_byte = s.acc;
                    cnt = cnt + 2'd1;
                    s.phase = PH_NONE;
                    s.digit_count = 2'd0;
                    s.acc = '0;
                    plain = 1'b1;
                end
            end else if (s.phase == PH_HEX) begin
                if (last || hv[4]) begin
                    res[cnt[0]].kind = KIND_BAD_ESC;
                    cnt = cnt + 2'd1;
                    if (last) begin
                        s = '0;
                    end else begin
                        s.err = 1'b1;
                    end
                end else begin
                    if (!s.digits_needed[0]) begin
                        s.acc = {4'd0, hv[3:0]};
                    end else begin
                        res[cnt[0]].out_byte = {s.acc[3:0], hv[3:0]};
                        cnt = cnt + 2'd1;
                        s.acc = '0;
                    end
                    s.digits_needed = s.digits_needed - 4'd1;
                    if (s.digits_needed == 4'd0) begin
                        s.phase = PH_NONE;
                    end
                end
            end else if (s.phase == PH_BSL) begin
                if (last) begin
                    res[cnt[0]].kind = KIND_BAD_ESC;
                    cnt = cnt + 2'd1;
                    s = '0;
                end else begin
                    s.phase = PH_NONE;
                    s.acc = '0;
                    if (c == CH_LOW_X || c == CH_LOW_U || c == CH_UP_U) begin
                        s.phase = PH_HEX;
                        s.digits_needed = (c == CH_LOW_X) ? 4'd2 :
                                          (c == CH_LOW_U) ? 4'd4 : 4'd8;
                    end else if (is_oct) begin
                        s.phase = PH_OCT;
                        s.acc = c - CH_ZERO;
                        s.digit_count = 2'd1;
                    end else begin
                        res[cnt[0]].out_byte = simple_escape(c);
                        cnt = cnt + 2'd1;
                    end
                end
            end else begin
                plain = 1'b1;
            end

            if (plain) begin
                if (last) begin
                    res[cnt[0]].kind = KIND_DONE;
                    cnt = cnt + 2'd1;
                    s = '0;
                end else if (c == CH_BSL) begin
                    s.phase = PH_BSL;
                end else begin
                    res[cnt[0]].out_byte = c;
                    cnt = cnt + 2'd1;
                end
            end
        end

        if (cnt == 2'd1) begin
            res[0].run_end = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].run_end = 1'b1;
        end

        o_state = s;
        o_res0  = res[0];
        o_res1  = res[1];
        o_count = cnt;
    end

endmodule

`default_nettype wire

/* sv/quoted_string_unescape_decoder.sv */
// Top level of the quoted string unescape decoder: state register, decode
// logic and a small result queue. Depends on qsud_pkg and qsud_decode.
//
//  channel   direction  payload      valid     stall
//  input     in         i_data       i_valid   o_stall
//  result    out        o_data       o_valid   i_stall
//
// One character is taken per cycle while o_stall is low; its results (zero,
// one or two) are written into a four-entry queue in that same cycle and leave
// one per cycle while i_stall is low. A result can be taken the cycle after its
// character's transfer. Input stalls only while the queue holds more than two
// results, i.e. while the output side is backed up. Synchronous active-low
// reset returns to idle and empties the queue.
`default_nettype none

module quoted_string_unescape_decoder
    import qsud_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire t_in_item i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_out_item  o_data,
    input  wire        i_stall
);

    localparam int unsigned PW = $clog2(QDEPTH);

    t_state        r_state;
    t_state        n_state;
    t_out_item     res0;
    t_out_item     res1;
    logic [1:0]    res_cnt;
    t_out_item     r_q [QDEPTH];
    logic [PW-1:0] r_rd;
    logic [PW-1:0] r_wr;
    logic [PW:0]   r_cnt;
    logic          in_xfer;
    logic          out_xfer;
    logic [1:0]    push;

    qsud_decode u_decode (
        .i_state (r_state),
        .i_item  (i_data),
        .o_state (n_state),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_cnt)
    );

    assign o_stall  = r_cnt > (PW+1)'(QDEPTH - 2);
    assign o_valid  = r_cnt != '0;
    assign o_data   = r_q[r_rd];
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;
    assign push     = in_xfer ? res_cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_cnt   <= '0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (out_xfer) begin
                r_rd <= r_rd + PW'(1);
            end
            r_wr  <= r_wr + PW'(push);
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(out_xfer);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (push == 2'd2) begin
            r_q[r_wr + PW'(1)] <= res1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QDEPTH))
        else $error("result queue overfilled");

    a_room_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_cnt <= (PW+1)'(QDEPTH - 2))
        else $error("transfer accepted without room for two results");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == MODE_IDLE |-> (r_state.phase == PH_NONE && !r_state.err))
        else $error("escape state left over while idle");

    a_hex_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_HEX |-> r_state.digits_needed != 4'd0)
        else $error("hex escape with no digits due");

    a_oct_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_OCT |-> (r_state.digit_count == 2'd1 ||
                                     r_state.digit_count == 2'd2))
        else $error("octal digit count out of range");

endmodule

`default_nettype wire
